// File: rtl/core/weighted_srpt_scheduler_core_assert.svh
// Assertion macros used by the port-level checker of the weighted SRPT scheduler.
`ifndef WEIGHTED_SRPT_SCHEDULER_CORE_ASSERT_SVH
`define WEIGHTED_SRPT_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define WSRPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define WSRPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wsrpt_pkg.sv
// Shared constants, payload types and helpers of the weighted SRPT scheduler.
package wsrpt_pkg;

    localparam int MAX_TASKS    = 64;
    localparam int IDX_W        = $clog2(MAX_TASKS);
    localparam int CNT_W        = $clog2(MAX_TASKS + 1);
    localparam int SERVED_IDX_W = 6;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] work_units;
        logic [31:0] release_tick;
        logic [15:0] task_weight;
    } wsrpt_in_t;

    typedef struct packed {
        logic                    served_valid;
        logic [SERVED_IDX_W-1:0] served_index;
        logic                    finished;
        logic [63:0]             weighted_total;
        logic                    all_done;
        logic [31:0]             tick_now;
    } wsrpt_out_t;

    // One task table entry as held in the memory.
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] rel;
        logic [15:0] w;
    } wsrpt_entry_t;

    localparam int ENTRY_W = $bits(wsrpt_entry_t);

    typedef struct packed {
        logic start;
        logic capture;
        logic decide;
    } wsrpt_scan_ctl_t;

    typedef struct packed {
        logic             have;
        logic [IDX_W-1:0] idx;
        wsrpt_entry_t     entry;
    } wsrpt_best_t;

    typedef struct packed {
        logic clear;
        logic multiply;
        logic accumulate;
    } wsrpt_acc_ctl_t;

    // Low bits of a table index as carried on the result.
    function automatic logic [SERVED_IDX_W-1:0] served_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SERVED_IDX_W-1:0] wide;
        wide = {{SERVED_IDX_W{1'b0}}, idx};
        return wide[SERVED_IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/wsrpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module wsrpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/wsrpt_scan.sv
// Candidate evaluation: eligibility, ratio cross products and best-task tracking.
module wsrpt_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsrpt_pkg::wsrpt_scan_ctl_t    ctl,
    input  wsrpt_pkg::wsrpt_entry_t       entry,
    input  logic [wsrpt_pkg::IDX_W-1:0]   entry_idx,
    input  logic [31:0]                   tick,
    output wsrpt_pkg::wsrpt_best_t        best
);

    logic                          best_have_reg;
    logic                          best_have_next;
    logic [wsrpt_pkg::IDX_W-1:0]   best_idx_reg;
    wsrpt_pkg::wsrpt_entry_t       best_entry_reg;
    logic [wsrpt_pkg::IDX_W-1:0]   cand_idx_reg;
    wsrpt_pkg::wsrpt_entry_t       cand_entry_reg;
    logic                          cand_elig_reg;
    logic [31:0]                   lhs_reg;
    logic [31:0]                   rhs_reg;
    logic                          elig;
    logic                          take;

    assign elig = (entry.rel <= tick) && (entry.rem != 16'd0);
    // A strictly higher ratio is needed to displace the held task, so ties keep it.
    assign take = ctl.decide && cand_elig_reg && (!best_have_reg || (lhs_reg > rhs_reg));

    always_comb
    begin
        best_have_next = best_have_reg;
        if (ctl.start)
        begin
            best_have_next = 1'b0;
        end
        else if (take)
        begin
            best_have_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_have_reg <= 1'b0;
        end
        else
        begin
            best_have_reg <= best_have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cand_idx_reg   <= entry_idx;
            cand_entry_reg <= entry;
            cand_elig_reg  <= elig;
            lhs_reg        <= {16'd0, entry.w} * {16'd0, best_entry_reg.rem};
            rhs_reg        <= {16'd0, best_entry_reg.w} * {16'd0, entry.rem};
        end
        if (take)
        begin
            best_idx_reg   <= cand_idx_reg;
            best_entry_reg <= cand_entry_reg;
        end
    end

    assign best = '{have: best_have_reg, idx: best_idx_reg, entry: best_entry_reg};

endmodule

// File: rtl/core/wsrpt_acc.sv
// Completion cost product and saturating weighted total.
module wsrpt_acc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wsrpt_pkg::wsrpt_acc_ctl_t  ctl,
    input  logic [31:0]                tick,
    input  logic [15:0]                weight,
    output logic [63:0]                total
);

    logic [48:0] prod_reg;
    logic [32:0] tick_inc;
    logic [64:0] sum;
    logic [63:0] total_reg;
    logic [63:0] total_next;

    assign tick_inc = {1'b0, tick} + 33'd1;
    assign sum      = {1'b0, total_reg} + {16'd0, prod_reg};

    always_comb
    begin
        total_next = total_reg;
        if (ctl.clear)
        begin
            total_next = 64'd0;
        end
        else if (ctl.accumulate)
        begin
            total_next = sum[64] ? {64{1'b1}} : sum[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.multiply)
        begin
            prod_reg <= {16'd0, tick_inc} * {33'd0, weight};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 64'd0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

// File: rtl/core/weighted_srpt_scheduler_core.sv
// Top level of the weighted shortest-remaining-processing-time scheduler.
//
// Usage: the input channel (in_valid, in_ready, in_data) carries one command per
// transaction. A load appends a task to a table of MAX_TASKS entries, a tick
// runs the server for one unit and a clear empties the table and the totals.
// Only a tick produces a transaction on the output channel (out_valid,
// out_ready, out_data); loads, clears and the unused mode produce none.
// Load, clear and unused commands are handled in the idle state itself. A
// tick walks the sequencer through a multiply and a compare step per entry
// visited, then an update step, an accumulate step when a task completes,
// and the output step. The table sits in one memory with a single read port;
// the multiply step forms the two ratio cross products and the compare step
// weighs them. The entries visited are the tasks in the table, plus the task
// kept from the previous tick when there is one. The sequencer works on one command
// at a time and takes the next command as soon as the tick's result sits in
// the output register, while that result still waits for the receiver.
// A receiver that stalls holds the result there; a further tick then waits at
// its final step until the register drains. Reset empties the table, zeroes
// the counters and the total, drops the kept task and needs no clearing pass,
// since only entries below the task count are ever read.
module weighted_srpt_scheduler_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  wsrpt_pkg::wsrpt_in_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output wsrpt_pkg::wsrpt_out_t  out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_UPD,
        S_ACC,
        S_OUT
    } state_t;

    state_t                        state_reg,      state_next;
    logic [wsrpt_pkg::CNT_W-1:0]   task_count_reg, task_count_next;
    logic [wsrpt_pkg::CNT_W-1:0]   done_count_reg, done_count_next;
    logic                          pick_valid_reg, pick_valid_next;
    logic [wsrpt_pkg::IDX_W-1:0]   pick_idx_reg,   pick_idx_next;
    logic [31:0]                   tick_reg,       tick_next;
    logic [wsrpt_pkg::IDX_W-1:0]   cur_idx_reg,    cur_idx_next;
    logic                          is_pick_reg,    is_pick_next;
    logic                          more_reg,       more_next;
    logic                          fin_reg,        fin_next;
    logic                          out_valid_reg,  out_valid_next;
    wsrpt_pkg::wsrpt_out_t         out_data_reg,   out_data_next;

    logic                          in_fire;
    logic [wsrpt_pkg::CNT_W-1:0]   cur_inc;
    logic                          more;
    logic [wsrpt_pkg::IDX_W-1:0]   next_idx;
    wsrpt_pkg::wsrpt_entry_t       load_entry;
    wsrpt_pkg::wsrpt_entry_t       wb_entry;

    logic                          ram_we;
    logic [wsrpt_pkg::IDX_W-1:0]   ram_waddr;
    logic [wsrpt_pkg::ENTRY_W-1:0] ram_wdata;
    logic                          ram_re;
    logic [wsrpt_pkg::IDX_W-1:0]   ram_raddr;
    logic [wsrpt_pkg::ENTRY_W-1:0] ram_rdata;

    wsrpt_pkg::wsrpt_scan_ctl_t    scan_ctl;
    wsrpt_pkg::wsrpt_acc_ctl_t     acc_ctl;
    wsrpt_pkg::wsrpt_best_t        best;
    logic [wsrpt_pkg::IDX_W-1:0]   cand_idx;
    logic [63:0]                   total;

    // Task table: remaining work, release tick and weight in one word per task.
    wsrpt_ram #(
        .WIDTH (wsrpt_pkg::ENTRY_W),
        .DEPTH (wsrpt_pkg::MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wsrpt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .entry     (wsrpt_pkg::wsrpt_entry_t'(ram_rdata)),
        .entry_idx (cand_idx),
        .tick      (tick_reg),
        .best      (best)
    );

    wsrpt_acc u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (acc_ctl),
        .tick   (tick_reg),
        .weight (best.entry.w),
        .total  (total)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The kept task is visited first, then the scan walks the table from index 0.
    assign cand_idx = is_pick_reg ? pick_idx_reg : cur_idx_reg;
    assign cur_inc  = wsrpt_pkg::CNT_W'({1'b0, cur_idx_reg}) + wsrpt_pkg::CNT_W'(1);
    assign more     = is_pick_reg ? (task_count_reg != '0) : (cur_inc < task_count_reg);
    assign next_idx = is_pick_reg ? '0 : cur_inc[wsrpt_pkg::IDX_W-1:0];

    assign load_entry = '{rem: in_data.work_units, rel: in_data.release_tick,
                          w: in_data.task_weight};

    always_comb
    begin
        wb_entry     = best.entry;
        wb_entry.rem = best.entry.rem - 16'd1;
    end

    always_comb
    begin
        state_next      = state_reg;
        task_count_next = task_count_reg;
        done_count_next = done_count_reg;
        pick_valid_next = pick_valid_reg;
        pick_idx_next   = pick_idx_reg;
        tick_next       = tick_reg;
        cur_idx_next    = cur_idx_reg;
        is_pick_next    = is_pick_reg;
        more_next       = more_reg;
        fin_next        = fin_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = task_count_reg[wsrpt_pkg::IDX_W-1:0];
        ram_wdata       = load_entry;
        ram_re          = 1'b0;
        ram_raddr       = cur_idx_reg;
        scan_ctl        = '0;
        acc_ctl         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.mode)
                        wsrpt_pkg::MODE_LOAD:
                        begin
                            // A load into a full table is dropped.
                            if (task_count_reg != wsrpt_pkg::CNT_W'(wsrpt_pkg::MAX_TASKS))
                            begin
                                ram_we          = 1'b1;
                                task_count_next = task_count_reg + wsrpt_pkg::CNT_W'(1);
                                if (in_data.work_units == 16'd0)
                                begin
                                    done_count_next = done_count_reg + wsrpt_pkg::CNT_W'(1);
                                end
                            end
                        end
                        wsrpt_pkg::MODE_TICK:
                        begin
                            scan_ctl.start = 1'b1;
                            if (pick_valid_reg)
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = pick_idx_reg;
                                is_pick_next = 1'b1;
                                state_next   = S_MUL;
                            end
                            else if (task_count_reg != '0)
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = '0;
                                cur_idx_next = '0;
                                is_pick_next = 1'b0;
                                state_next   = S_MUL;
                            end
                            else
                            begin
                                state_next = S_UPD;
                            end
                        end
                        wsrpt_pkg::MODE_CLEAR:
                        begin
                            task_count_next = '0;
                            done_count_next = '0;
                            pick_valid_next = 1'b0;
                            tick_next       = 32'd0;
                            acc_ctl.clear   = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                // The read for the following entry goes out now; its data then
                // stays in the RAM output register until this entry is decided.
                scan_ctl.capture = 1'b1;
                more_next        = more;
                is_pick_next     = 1'b0;
                if (more)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = next_idx;
                    cur_idx_next = next_idx;
                end
                state_next = S_CMP;
            end
            S_CMP:
            begin
                scan_ctl.decide = 1'b1;
                state_next      = more_reg ? S_MUL : S_UPD;
            end
            S_UPD:
            begin
                if (best.have)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = best.idx;
                    ram_wdata = wb_entry;
                    if (best.entry.rem == 16'd1)
                    begin
                        fin_next         = 1'b1;
                        pick_valid_next  = 1'b0;
                        done_count_next  = done_count_reg + wsrpt_pkg::CNT_W'(1);
                        acc_ctl.multiply = 1'b1;
                        state_next       = S_ACC;
                    end
                    else
                    begin
                        fin_next        = 1'b0;
                        pick_valid_next = 1'b1;
                        pick_idx_next   = best.idx;
                        state_next      = S_OUT;
                    end
                end
                else
                begin
                    fin_next        = 1'b0;
                    pick_valid_next = 1'b0;
                    state_next      = S_OUT;
                end
            end
            S_ACC:
            begin
                acc_ctl.accumulate = 1'b1;
                state_next         = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.served_valid    = best.have;
                    out_data_next.served_index    = best.have ?
                                                    wsrpt_pkg::served_idx(best.idx) : '0;
                    out_data_next.finished        = fin_reg;
                    out_data_next.weighted_total  = total;
                    out_data_next.all_done        = (done_count_reg == task_count_reg);
                    out_data_next.tick_now        = tick_reg;
                    tick_next                     = tick_reg + 32'd1;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            task_count_reg <= '0;
            done_count_reg <= '0;
            pick_valid_reg <= 1'b0;
            pick_idx_reg   <= '0;
            tick_reg       <= 32'd0;
            cur_idx_reg    <= '0;
            is_pick_reg    <= 1'b0;
            more_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            task_count_reg <= task_count_next;
            done_count_reg <= done_count_next;
            pick_valid_reg <= pick_valid_next;
            pick_idx_reg   <= pick_idx_next;
            tick_reg       <= tick_next;
            cur_idx_reg    <= cur_idx_next;
            is_pick_reg    <= is_pick_next;
            more_reg       <= more_next;
            fin_reg        <= fin_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

endmodule

// File: rtl/core/wsrpt_checker.sv
// Port-level checker of the weighted SRPT scheduler and its bind.
`include "weighted_srpt_scheduler_core_assert.svh"

module wsrpt_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input wsrpt_pkg::wsrpt_in_t   in_data,
    input logic                   out_valid,
    input logic                   out_ready,
    input wsrpt_pkg::wsrpt_out_t  out_data
);

    // A stalled result transaction must hold.
    `WSRPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // An idle tick reports neither an index nor a completion.
    `WSRPT_ASSERT_IMP(a_idle_clean, out_valid && !out_data.served_valid, !out_data.finished && (out_data.served_index == '0), "idle tick carries served fields")

    // Completion is only reported for a task that was served.
    `WSRPT_ASSERT_IMP(a_fin_served, out_valid && out_data.finished, out_data.served_valid, "completion without a served task")

    // A tick occupies the sequencer, so no command is taken in the next cycle.
    `WSRPT_ASSERT_NXT(a_tick_busy, in_valid && in_ready && (in_data.mode == wsrpt_pkg::MODE_TICK), !in_ready, "command taken while a tick is in progress")

endmodule

bind weighted_srpt_scheduler_core wsrpt_checker u_wsrpt_checker (.*);

// File: tb/weighted_srpt_scheduler_checker.sv
`timescale 1ns / 100ps
// Checker that mirrors the scheduler state and compares every tick report against it.
module weighted_srpt_scheduler_checker
    import wsrpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  wsrpt_in_t  in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  wsrpt_out_t out_data,
    output int         errors,
    output int         reports_owed
);

    logic [15:0] work_left  [MAX_TASKS];
    logic [31:0] release_at [MAX_TASKS];
    logic [15:0] task_wt    [MAX_TASKS];
    int unsigned n_loaded;
    int unsigned n_done;
    bit          keep_valid;
    int unsigned keep_idx;
    logic [31:0] tick_ctr;
    logic [63:0] cost_total;

    wsrpt_out_t  tick_reports_due[$];
    wsrpt_out_t  due;
    int          err_cnt;
    int          shown;

    function automatic bit runnable(input int unsigned i);
        return i < n_loaded && release_at[i] <= tick_ctr && work_left[i] != 16'd0;
    endfunction

    // Strictly higher weight per remaining unit, by cross products.
    function automatic bit outranks(input int unsigned a, input int unsigned b);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = 32'(task_wt[a]) * 32'(work_left[b]);
        rhs = 32'(task_wt[b]) * 32'(work_left[a]);
        return lhs > rhs;
    endfunction

    function automatic wsrpt_out_t serve_one_tick();
        bit          have;
        bit          fin;
        int unsigned best;
        logic [63:0] add;
        wsrpt_out_t  rpt;
        have = 1'b0;
        fin  = 1'b0;
        best = 0;
        if (keep_valid && keep_idx < MAX_TASKS && runnable(keep_idx)) begin
            have = 1'b1;
            best = keep_idx;
        end
        for (int unsigned i = 0; i < n_loaded && i < MAX_TASKS; i++) begin
            if (runnable(i)) begin
                if (!have) begin
                    have = 1'b1;
                    best = i;
                end else if (outranks(i, best)) begin
                    best = i;
                end
            end
        end
        if (have) begin
            work_left[best] = work_left[best] - 16'd1;
            if (work_left[best] == 16'd0) begin
                add        = (64'(tick_ctr) + 64'd1) * 64'(task_wt[best]);
                cost_total = (cost_total > ~64'd0 - add) ? ~64'd0 : cost_total + add;
                n_done++;
                fin        = 1'b1;
                keep_valid = 1'b0;
            end else begin
                keep_valid = 1'b1;
                keep_idx   = best;
            end
        end else begin
            keep_valid = 1'b0;
        end
        rpt.served_valid   = have;
        rpt.served_index   = have ? SERVED_IDX_W'(best) : '0;
        rpt.finished       = fin;
        rpt.weighted_total = cost_total;
        rpt.all_done       = (n_done == n_loaded);
        rpt.tick_now       = tick_ctr;
        tick_ctr           = tick_ctr + 32'd1;
        return rpt;
    endfunction

    function automatic void wipe_table();
        n_loaded   = 0;
        n_done     = 0;
        keep_valid = 1'b0;
        keep_idx   = 0;
        tick_ctr   = '0;
        cost_total = '0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wipe_table();
            tick_reports_due.delete();
            err_cnt      = 0;
            shown        = 0;
            errors       <= 0;
            reports_owed <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (tick_reports_due.size() == 0) begin
                    err_cnt++;
                    if (shown < 10) begin
                        shown++;
                        $display("%0t: unexpected tick report %p", $time, out_data);
                    end
                end else begin
                    due = tick_reports_due.pop_front();
                    if (out_data.served_valid   !== due.served_valid   ||
                        out_data.served_index   !== due.served_index   ||
                        out_data.finished       !== due.finished       ||
                        out_data.weighted_total !== due.weighted_total ||
                        out_data.all_done       !== due.all_done       ||
                        out_data.tick_now       !== due.tick_now) begin
                        err_cnt++;
                        if (shown < 10) begin
                            shown++;
                            $display("%0t: tick report mismatch", $time);
                            $display("  expected valid=%b index=%0d finished=%b total=%0d done=%b tick=%0d",
                                     due.served_valid, due.served_index, due.finished,
                                     due.weighted_total, due.all_done, due.tick_now);
                            $display("  actual   valid=%b index=%0d finished=%b total=%0d done=%b tick=%0d",
                                     out_data.served_valid, out_data.served_index,
                                     out_data.finished, out_data.weighted_total,
                                     out_data.all_done, out_data.tick_now);
                        end
                    end
                end
            end
            if (in_valid && in_ready) begin
                case (in_data.mode)
                    MODE_LOAD: begin
                        if (n_loaded < MAX_TASKS) begin
                            work_left[n_loaded]  = in_data.work_units;
                            release_at[n_loaded] = in_data.release_tick;
                            task_wt[n_loaded]    = in_data.task_weight;
                            if (in_data.work_units == 16'd0)
                                n_done++;
                            n_loaded++;
                        end
                    end
                    MODE_TICK:  tick_reports_due.push_back(serve_one_tick());
                    MODE_CLEAR: wipe_table();
                    default:    ;
                endcase
            end
            errors       <= err_cnt;
            reports_owed <= tick_reports_due.size();
        end
    end

endmodule

// File: tb/weighted_srpt_scheduler_core_test.sv
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, command stimulus, receiver and verdict.
module weighted_srpt_scheduler_core_test;

    // The fourth mode encoding is not used by the scheduler; it must be ignored.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Number of commands after which the random part stops.
    localparam int COMMAND_TARGET = 1200;

    // Length of the one deliberate receiver hold-off, in clock cycles. It is far
    // longer than several ticks, so the output register fills and the input stalls.
    localparam int LONG_HOLD = 400;

    // Cycles allowed after the last report, well beyond the longest tick, which
    // visits a full table plus the kept task.
    localparam int DRAIN_CYCLES = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    wsrpt_pkg::wsrpt_in_t  in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    wsrpt_pkg::wsrpt_out_t out_data;

    int          fail_total;
    int          results_owed;
    bit          hold_req = 1'b0;
    int          commands_sent = 0;
    int unsigned loaded = 0;
    logic [31:0] ticks_since_clear = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    weighted_srpt_scheduler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    weighted_srpt_scheduler_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .errors       (fail_total),
        .reports_owed (results_owed)
    );

    // Offers one command and waits for its transaction. Valid stays high with
    // the payload unchanged until accepted; afterwards the line idles for a
    // random gap, mostly none or short, now and then long. With no gap the next
    // command simply replaces the payload in the same time step.
    task automatic issue(input logic [1:0] mode, input logic [15:0] work,
                         input logic [31:0] rel, input logic [15:0] wt);
        wsrpt_pkg::wsrpt_in_t cmd;
        int                   gap;
        int                   roll;
        cmd.mode         = mode;
        cmd.work_units   = work;
        cmd.release_tick = rel;
        cmd.task_weight  = wt;
        in_data  <= cmd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Simple bookkeeping to steer the episodes; loads into a full table and
        // the unused mode are ignored by the block and are not counted.
        case (mode)
            wsrpt_pkg::MODE_LOAD:
            begin
                if (loaded < wsrpt_pkg::MAX_TASKS)
                begin
                    loaded++;
                    commands_sent++;
                end
            end
            wsrpt_pkg::MODE_TICK:
            begin
                ticks_since_clear++;
                commands_sent++;
            end
            wsrpt_pkg::MODE_CLEAR:
            begin
                loaded            = 0;
                ticks_since_clear = '0;
                commands_sent++;
            end
            default: ;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 60)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else if (roll < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Commands other than a load carry random content in the unused fields, so
    // that the block is seen to ignore them.
    task automatic issue_plain(input logic [1:0] mode);
        issue(mode, 16'($urandom), $urandom, 16'($urandom));
    endtask

    // Lowers valid and waits until every tick report has come back. The first
    // edge lets the checker account for a transaction taken at this very edge.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // One scheduling episode: usually a clear, then a batch of task loads with
    // ticks and the odd stray command mixed in, then enough ticks for most of
    // the short tasks to be released and run to completion. A few episodes load
    // past the table size to exercise the full-table case.
    task automatic run_episode(input bit with_hold);
        int          n_tasks;
        int          need;
        int          lead;
        int          roll;
        logic [15:0] work;
        logic [31:0] rel;
        logic [15:0] wt;
        n_tasks = ($urandom_range(0, 99) < 6) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        if ($urandom_range(0, 9) != 0)
            issue_plain(wsrpt_pkg::MODE_CLEAR);
        need = 0;
        lead = 0;
        for (int k = 0; k < n_tasks; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                work = 16'd0;
            else if (roll < 80)
                work = 16'($urandom_range(1, 4));
            else if (roll < 95)
                work = 16'($urandom_range(5, 40));
            else
                work = 16'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                rel = '0;
            end
            else if (roll < 85)
            begin
                rel = ticks_since_clear + 32'($urandom_range(0, 20));
                if (int'(rel - ticks_since_clear) > lead)
                    lead = int'(rel - ticks_since_clear);
            end
            else if (roll < 93)
            begin
                rel = $urandom;
            end
            else
            begin
                rel = 32'hFFFF_FFFF;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8)
                wt = 16'd0;
            else if (roll < 16)
                wt = 16'hFFFF;
            else if (roll < 50)
                wt = 16'($urandom_range(1, 4));
            else
                wt = 16'($urandom);
            if (work <= 16'd40 && loaded < wsrpt_pkg::MAX_TASKS)
                need += int'(work);
            issue(wsrpt_pkg::MODE_LOAD, work, rel, wt);
            roll = $urandom_range(0, 99);
            if (roll < 30)
                issue_plain(wsrpt_pkg::MODE_TICK);
            else if (roll < 33)
                issue_plain(MODE_UNUSED);
            else if (roll < 35)
                issue_plain(wsrpt_pkg::MODE_CLEAR);
        end
        // The receiver takes up the request in its own process while ticks keep coming.
        if (with_hold)
            hold_req = 1'b1;
        need += lead + $urandom_range(0, 4);
        if (with_hold && need < 12)
            need = 12;
        repeat (need) issue_plain(wsrpt_pkg::MODE_TICK);
    endtask

    // Receiver: mostly ready, with short and occasional long stalls, stretches
    // of steady readiness, and one long hold-off when the stimulus asks for it.
    initial
    begin
        int roll;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end
                else if (roll < 75)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(20, 100)) @(posedge clk);
                end
                else if (roll < 97)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(20, 80)) @(posedge clk);
                end
            end
        end
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int episode;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An idle tick on an empty table, which also counts as
        // all done, and the unused mode.
        issue_plain(wsrpt_pkg::MODE_TICK);
        issue_plain(MODE_UNUSED);
        // A zero-work task, done at load and never served, and a task that is
        // never released, with the extreme work and weight values.
        issue(wsrpt_pkg::MODE_LOAD, 16'd0, 32'd0, 16'hFFFF);
        issue(wsrpt_pkg::MODE_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
        // The task loaded third is released at tick two with a ratio equal to
        // the one the fourth task reaches after its first unit, so the running
        // task must be kept on the tie rather than the lower index taken.
        issue(wsrpt_pkg::MODE_LOAD, 16'd1, 32'd2, 16'd1);
        issue(wsrpt_pkg::MODE_LOAD, 16'd2, 32'd0, 16'd1);
        issue(wsrpt_pkg::MODE_LOAD, 16'd1, 32'd3, 16'hFFFF);
        // Completions of the kept task, the heavy task and its rival, then idle
        // ticks with an unfinished task left in the table.
        repeat (6) issue_plain(wsrpt_pkg::MODE_TICK);
        // Clear mid-stream restarts the tick count and the total.
        issue_plain(wsrpt_pkg::MODE_CLEAR);
        issue_plain(wsrpt_pkg::MODE_TICK);
        issue(wsrpt_pkg::MODE_LOAD, 16'd2, 32'd0, 16'hFFFF);
        issue(wsrpt_pkg::MODE_LOAD, 16'd3, 32'd0, 16'hFFFF);
        repeat (6) issue_plain(wsrpt_pkg::MODE_TICK);

        // Sender pause: everything outstanding must come back first.
        settle();

        // Random part, in episodes. The second episode carries the long
        // receiver hold-off, and one later pause drains the block once more.
        episode = 0;
        while (commands_sent < COMMAND_TARGET)
        begin
            run_episode(episode == 1);
            if (episode == 4)
                settle();
            episode++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_total == 0 && results_owed == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/wsrpt_pkg.sv
rtl/core/wsrpt_ram.sv
rtl/core/wsrpt_scan.sv
rtl/core/wsrpt_acc.sv
rtl/core/weighted_srpt_scheduler_core.sv
rtl/core/wsrpt_checker.sv
tb/weighted_srpt_scheduler_checker.sv
tb/weighted_srpt_scheduler_core_test.sv
